// ===== hw/rtl/mgx_pkg.sv =====
// Shared types, constants and helpers for the mono glyph expander.
package mgx_pkg;

  localparam int COORD_BITS = 12;
  localparam int DIM_BITS   = 8;
  localparam int LB_W       = 15;
  localparam int COLOR_W    = 32;
  localparam int OFF_W      = 26;
  localparam int COL_W      = DIM_BITS + 3;
  localparam int XB_W       = ((COORD_BITS > COL_W) ? COORD_BITS : COL_W) + 1;
  localparam int PROD_W     = COORD_BITS + LB_W;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BPP_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR   = 2'd2;

  // Pixel modes
  localparam logic [1:0] MODE_8BPP  = 2'd0;
  localparam logic [1:0] MODE_16BPP = 2'd1;
  localparam logic [1:0] MODE_32BPP = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // Request kinds
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;

  localparam logic [LB_W-1:0]    LINE_BYTES_RST = 15'd3200;
  localparam logic [COLOR_W-1:0] FG_COLOR_RST   = 32'hffff_ffff;

  typedef struct packed {
    logic [1:0]         bpp_mode;
    logic [LB_W-1:0]    line_bytes;
    logic [COLOR_W-1:0] fg_color;
  } cfg_t;

  // One byte's worth of work: bit k set means column k (leftmost = 0) is written
  typedef struct packed {
    logic [7:0]       mask;
    logic [OFF_W-1:0] row_off;
    logic [XB_W-1:0]  xbase;
  } job_t;

  function automatic logic [COLOR_W-1:0] fmt_color(input logic [1:0] mode,
                                                   input logic [COLOR_W-1:0] c);
    logic [COLOR_W-1:0] res;
    res = c;
    case (mode)
      MODE_8BPP:  res = {24'd0, c[7:0]};
      MODE_16BPP: res = {16'd0, c[23:19], c[15:10], c[7:3]};
      default:    res = c;
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/mgx_front.sv =====
// Front end: accepts start and byte beats, tracks glyph position, builds jobs.
module mgx_front
  import mgx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [COORD_BITS-1:0] glyph_x,
  input  logic [COORD_BITS-1:0] glyph_y,
  input  logic [DIM_BITS-1:0]   glyph_width,
  input  logic [DIM_BITS-1:0]   glyph_rows,
  input  logic [DIM_BITS-1:0]   row_pitch,
  input  logic [7:0]            bitmap_byte,
  input  logic                  q_full,
  output logic                  q_push,
  output job_t                  q_job
);

  logic [COORD_BITS-1:0] origin_x;
  logic [COORD_BITS-1:0] row_y;
  logic [DIM_BITS-1:0]   width_px;
  logic [DIM_BITS-1:0]   rows_left;
  logic [DIM_BITS-1:0]   pitch_bytes;
  logic [DIM_BITS-1:0]   byte_in_row;

  logic                  accept;
  logic [DIM_BITS:0]     need_sum;
  logic [DIM_BITS-1:0]   need;
  logic [DIM_BITS-1:0]   pitch_next;
  logic [COL_W-1:0]      base_col;
  logic [7:0]            mask;
  logic [PROD_W-1:0]     prod;
  logic [DIM_BITS-1:0]   bir_inc;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Start: minimum pitch is ceil(width/8)
  assign need_sum   = {1'b0, glyph_width} + (DIM_BITS+1)'(7);
  assign need       = DIM_BITS'(need_sum >> 3);
  assign pitch_next = (row_pitch < need) ? need : row_pitch;

  // Columns covered by this byte that are set and inside the glyph
  assign base_col = {byte_in_row, 3'b000};
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      mask[k] = bitmap_byte[7-k] && ((base_col + COL_W'(k)) < COL_W'(width_px));
    end
  end

  assign prod = PROD_W'(row_y) * PROD_W'(cfg.line_bytes);

  assign q_job.mask    = mask;
  assign q_job.row_off = OFF_W'(prod);
  assign q_job.xbase   = XB_W'(origin_x) + XB_W'(base_col);

  assign q_push = accept && (req_type == REQ_BYTE) && (rows_left != '0) &&
                  (cfg.bpp_mode != MODE_NONE) && (mask != '0);

  assign bir_inc = byte_in_row + DIM_BITS'(1);

  // Glyph state
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      row_y       <= '0;
      width_px    <= '0;
      rows_left   <= '0;
      pitch_bytes <= '0;
      byte_in_row <= '0;
    end else if (accept) begin
      if (req_type == REQ_START) begin
        origin_x    <= glyph_x;
        row_y       <= glyph_y;
        width_px    <= glyph_width;
        pitch_bytes <= pitch_next;
        rows_left   <= (pitch_next == '0) ? '0 : glyph_rows;
        byte_in_row <= '0;
      end else if (rows_left != '0) begin
        if (bir_inc >= pitch_bytes) begin
          byte_in_row <= '0;
          row_y       <= row_y + COORD_BITS'(1);
          rows_left   <= rows_left - DIM_BITS'(1);
        end else begin
          byte_in_row <= bir_inc;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/mgx_fifo.sv =====
// Two-entry job queue between front and back ends.
module mgx_fifo
  import mgx_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t pop_job
);

  job_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_job   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_job;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/mgx_back.sv =====
// Back end: walks each job's set columns; a write beat a cycle if not stalled.
module mgx_back
  import mgx_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               q_not_empty,
  input  job_t               q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [OFF_W-1:0]   pixel_offset,
  output logic [COLOR_W-1:0] pixel_data,
  output logic [1:0]         write_size,
  output logic               last_write
);

  logic             cur_valid;
  job_t             cur;
  logic             step;
  logic             done;
  logic [2:0]       k;
  logic [7:0]       mask_rest;
  logic [XB_W-1:0]  x;
  logic [XB_W+1:0]  x_bytes;
  logic             load;

  // Leftmost remaining column
  always_comb begin
    k = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (cur.mask[i]) k = 3'(i);
    end
  end

  assign mask_rest = cur.mask & (cur.mask - 8'd1);
  assign done      = (mask_rest == '0);
  assign step      = cur_valid && (!out_valid || out_ready);
  assign load      = (!cur_valid || (step && done)) && q_not_empty;
  assign q_pop     = load;

  assign x = cur.xbase + XB_W'(k);
  always_comb begin
    case (cfg.bpp_mode)
      MODE_8BPP:  x_bytes = {2'b00, x};
      MODE_16BPP: x_bytes = {1'b0, x, 1'b0};
      default:    x_bytes = {x, 2'b00};
    endcase
  end

  // Current job
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (load) begin
      cur_valid <= 1'b1;
    end else if (step && done) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_job;
    end else if (step) begin
      cur.mask <= mask_rest;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pixel_offset <= cur.row_off + OFF_W'(x_bytes);
      pixel_data   <= fmt_color(cfg.bpp_mode, cfg.fg_color);
      write_size   <= cfg.bpp_mode;
      last_write   <= done;
    end
  end

endmodule

// ===== hw/rtl/mono_glyph_expand_to_framebuffer_top.sv =====
// Top level of the mono glyph expander: config registers, front, queue, back.
//
// Usage: write bpp_mode, line_bytes and fg_color on the cfg channel (index 0..2)
// while the block is idle; cfg_ready is always high. Then send a start beat
// (req_type 0) with glyph geometry, followed by bitmap byte beats (req_type 1)
// in row order. Each byte yields up to eight write beats on the out channel,
// one per set in-width column, left to right; last_write marks the final one.
// The first write of a byte passes the job queue, the current-job register and
// the output register before it appears on the out channel.
// Throughput: the back end emits one write beat per cycle while the receiver
// accepts, one beat per set pixel of a byte; bytes with no writes take none of
// the back end's time. The input side is paced by the two-entry job queue.
// Reset: config returns to 32 bpp, 3200 bytes per line, white; no glyph active.
// When the receiver stalls, the output register holds its beat, the back end
// waits, and once the queue fills in_ready drops.
module mono_glyph_expand_to_framebuffer_top
  import mgx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COLOR_W-1:0]    cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [COORD_BITS-1:0] glyph_x,
  input  logic [COORD_BITS-1:0] glyph_y,
  input  logic [DIM_BITS-1:0]   glyph_width,
  input  logic [DIM_BITS-1:0]   glyph_rows,
  input  logic [DIM_BITS-1:0]   row_pitch,
  input  logic [7:0]            bitmap_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OFF_W-1:0]      pixel_offset,
  output logic [COLOR_W-1:0]    pixel_data,
  output logic [1:0]            write_size,
  output logic                  last_write
);

  cfg_t cfg;
  logic q_full;
  logic q_push;
  job_t q_in;
  logic q_pop;
  logic q_not_empty;
  job_t q_out;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bpp_mode   <= MODE_32BPP;
      cfg.line_bytes <= LINE_BYTES_RST;
      cfg.fg_color   <= FG_COLOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BPP_MODE:   cfg.bpp_mode   <= cfg_data[1:0];
        CFG_LINE_BYTES: cfg.line_bytes <= cfg_data[LB_W-1:0];
        CFG_FG_COLOR:   cfg.fg_color   <= cfg_data;
        default:        ;
      endcase
    end
  end

  mgx_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .glyph_x     (glyph_x),
    .glyph_y     (glyph_y),
    .glyph_width (glyph_width),
    .glyph_rows  (glyph_rows),
    .row_pitch   (row_pitch),
    .bitmap_byte (bitmap_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (q_in)
  );

  mgx_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_job   (q_out)
  );

  mgx_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_not_empty  (q_not_empty),
    .q_job        (q_out),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_offset (pixel_offset),
    .pixel_data   (pixel_data),
    .write_size   (write_size),
    .last_write   (last_write)
  );

endmodule
